// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the modular exponentiation RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as trig
`define ASSERT_IMPLIES(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// cons must hold in the cycle after trig
`define ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== hdl/modexp_pkg.sv =====
// ---------------------------------------------------------------------------
// modexp_pkg
// Types, widths and constants shared by the modular exponentiation block.
// ---------------------------------------------------------------------------
package modexp_pkg;

   localparam int MOD_W       = 31;
   localparam int EXP_W       = 63;
   localparam int BITS_W      = 6;            // holds EXP_W
   localparam int MUL_OP_W    = 32;           // MOD_W padded to two bits per step
   localparam int MUL_CNT_W   = 4;            // MUL_OP_W / 2 steps
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [MOD_W-1:0]     MODULUS_RESET = 31'd1000000007;
   localparam logic [MUL_CNT_W-1:0] MUL_LAST      = 4'd15;
   localparam logic [BITS_W-1:0]    EXP_BITS      = 6'd63;

   // register index, taken from paddr[2]
   localparam logic REG_MODULUS = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_REDUCE,
      ST_SCAN,
      ST_SQUARE,
      ST_MULTIPLY,
      ST_FINISH
   } modexp_state_type;

   typedef enum logic [1:0] {
      OPSEL_REDUCE,     // base * 1
      OPSEL_SQUARE,     // acc * acc
      OPSEL_MULBASE     // fresh square * base
   } modexp_opsel_type;

   typedef struct packed {
      logic             load;
      logic             mul_start;
      modexp_opsel_type opsel;
      logic             acc_from_base;
      logic             acc_from_mul;
      logic             base_from_mul;
      logic             exp_shift;
      logic             out_load;
   } modexp_cmd_type;

   typedef struct packed {
      logic mod_small;
      logic mul_busy;
      logic exp_msb;
      logic exp_empty;
   } modexp_sts_type;

endpackage

// ===== hdl/modexp_dp.sv =====
// ---------------------------------------------------------------------------
// modexp_dp
// Datapath: operand registers, exponent shifter and a radix-4 interleaved
// modular multiplier (two shift-add-reduce steps per cycle).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module modexp_dp
   import modexp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [MOD_W-1:0]     modulus,
   input  logic [MOD_W-1:0]     req_base,
   input  logic [EXP_W-1:0]     req_exponent,
   input  modexp_cmd_type       cmd,
   output modexp_sts_type       sts,
   output logic [MOD_W-1:0]     rsp_result
);

   // r <- (2r + bit*addend) mod m, with r, addend < m
   function automatic logic [MOD_W-1:0] mm_step(
      input logic [MOD_W-1:0] r,
      input logic             bit_in,
      input logic [MOD_W-1:0] addend,
      input logic [MOD_W-1:0] m
   );
      logic [MOD_W+1:0] t;
      logic [MOD_W+1:0] m1;
      logic [MOD_W+1:0] m2;
      logic [MOD_W+1:0] res;
      t  = {1'b0, r, 1'b0} + (bit_in ? {2'b00, addend} : '0);
      m1 = {2'b00, m};
      m2 = {1'b0, m, 1'b0};
      if (t >= m2) begin
         res = t - m2;
      end else if (t >= m1) begin
         res = t - m1;
      end else begin
         res = t;
      end
      return res[MOD_W-1:0];
   endfunction

   logic [MOD_W-1:0]     base_ff, base_in;
   logic [MOD_W-1:0]     acc_ff, acc_in;
   logic [EXP_W-1:0]     exp_ff, exp_in;
   logic [BITS_W-1:0]    bits_left_ff, bits_left_in;
   logic [MUL_OP_W-1:0]  ma_ff, ma_in;
   logic [MOD_W-1:0]     mb_ff, mb_in;
   logic [MOD_W-1:0]     mr_ff, mr_in;
   logic [MUL_CNT_W-1:0] mcnt_ff, mcnt_in;
   logic                 mul_busy_ff, mul_busy_in;
   logic [MOD_W-1:0]     result_ff, result_in;
   logic [MOD_W-1:0]     step_one;
   logic [MOD_W-1:0]     step_two;
   logic                 mod_small;

   assign mod_small = (modulus < 31'd2);
   assign step_one  = mm_step(mr_ff, ma_ff[MUL_OP_W-1], mb_ff, modulus);
   assign step_two  = mm_step(step_one, ma_ff[MUL_OP_W-2], mb_ff, modulus);

   always_comb begin
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      bits_left_in = bits_left_ff;
      result_in    = result_ff;

      if (cmd.load) begin
         base_in      = req_base;
         exp_in       = req_exponent;
         bits_left_in = EXP_BITS;
         acc_in       = mod_small ? '0 : {{(MOD_W-1){1'b0}}, 1'b1};
      end
      if (cmd.base_from_mul) begin
         base_in = mr_ff;
      end
      if (cmd.acc_from_base) begin
         acc_in = base_ff;
      end
      if (cmd.acc_from_mul) begin
         acc_in = mr_ff;
      end
      if (cmd.exp_shift) begin
         exp_in       = {exp_ff[EXP_W-2:0], 1'b0};
         bits_left_in = bits_left_ff - 1'b1;
      end
      if (cmd.out_load) begin
         result_in = acc_ff;
      end
   end

   // multiplier operand select and stepping
   always_comb begin
      ma_in       = ma_ff;
      mb_in       = mb_ff;
      mr_in       = mr_ff;
      mcnt_in     = mcnt_ff;
      mul_busy_in = mul_busy_ff;

      if (cmd.mul_start) begin
         mr_in       = '0;
         mcnt_in     = '0;
         mul_busy_in = 1'b1;
         case (cmd.opsel)
            OPSEL_REDUCE: begin
               ma_in = {1'b0, base_ff};
               mb_in = {{(MOD_W-1){1'b0}}, 1'b1};
            end
            OPSEL_SQUARE: begin
               ma_in = {1'b0, acc_ff};
               mb_in = acc_ff;
            end
            OPSEL_MULBASE: begin
               ma_in = {1'b0, mr_ff};
               mb_in = base_ff;
            end
            default: begin
               ma_in = '0;
               mb_in = '0;
            end
         endcase
      end else if (mul_busy_ff) begin
         mr_in   = step_two;
         ma_in   = {ma_ff[MUL_OP_W-3:0], 2'b00};
         mcnt_in = mcnt_ff + 1'b1;
         if (mcnt_ff == MUL_LAST) begin
            mul_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
      end else begin
         mul_busy_ff <= mul_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      acc_ff       <= acc_in;
      exp_ff       <= exp_in;
      bits_left_ff <= bits_left_in;
      ma_ff        <= ma_in;
      mb_ff        <= mb_in;
      mr_ff        <= mr_in;
      mcnt_ff      <= mcnt_in;
      result_ff    <= result_in;
   end

   assign sts.mod_small = mod_small;
   assign sts.mul_busy  = mul_busy_ff;
   assign sts.exp_msb   = exp_ff[EXP_W-1];
   assign sts.exp_empty = (bits_left_ff == '0);
   assign rsp_result    = result_ff;

   `ASSERT_IMPLIES(a_mul_reduced, clock, reset, $fell(mul_busy_ff), mr_ff < modulus, "product not reduced below modulus")
   `ASSERT_IMPLIES(a_shift_in_range, clock, reset, cmd.exp_shift, bits_left_ff != '0, "exponent shifted past its last bit")

endmodule

// ===== hdl/modexp_ctrl.sv =====
// ---------------------------------------------------------------------------
// modexp_ctrl
// Sequencer for square-and-multiply; owns the input and output handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module modexp_ctrl
   import modexp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  modexp_sts_type sts,
   output modexp_cmd_type cmd
);

   modexp_state_type state_ff, state_in;
   logic             started_ff, started_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.mod_small ? ST_FINISH : ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (!sts.mul_busy) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.exp_empty) begin
               state_in = ST_FINISH;
            end else if (started_ff) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (!sts.mul_busy) begin
               state_in = sts.exp_msb ? ST_MULTIPLY : ST_SCAN;
            end
         end
         ST_MULTIPLY: begin
            if (!sts.mul_busy) begin
               state_in = ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      cmd.opsel  = OPSEL_REDUCE;
      started_in = started_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               started_in = 1'b0;
            end
         end
         ST_PREP: begin
            cmd.mul_start = 1'b1;
            cmd.opsel     = OPSEL_REDUCE;
         end
         ST_REDUCE: begin
            cmd.base_from_mul = !sts.mul_busy;
         end
         ST_SCAN: begin
            if (!sts.exp_empty) begin
               if (started_ff) begin
                  cmd.mul_start = 1'b1;
                  cmd.opsel     = OPSEL_SQUARE;
               end else begin
                  // running value is 1: squaring is a no-op
                  cmd.exp_shift = 1'b1;
                  if (sts.exp_msb) begin
                     cmd.acc_from_base = 1'b1;
                     started_in        = 1'b1;
                  end
               end
            end
         end
         ST_SQUARE: begin
            if (!sts.mul_busy) begin
               cmd.acc_from_mul = 1'b1;
               if (sts.exp_msb) begin
                  cmd.mul_start = 1'b1;
                  cmd.opsel     = OPSEL_MULBASE;
               end else begin
                  cmd.exp_shift = 1'b1;
               end
            end
         end
         ST_MULTIPLY: begin
            if (!sts.mul_busy) begin
               cmd.acc_from_mul = 1'b1;
               cmd.exp_shift    = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_IMPLIES(a_start_when_free, clock, reset, cmd.mul_start, !sts.mul_busy, "multiplier restarted while busy")
   `ASSERT_NEXT(a_finish_loads, clock, reset, cmd.out_load, rsp_valid_ff, "result load did not raise rsp_valid")

endmodule

// ===== hdl/modular_exponentiation.sv =====
// Accept to rsp_valid: a modulus below 2 goes straight to the finish state; otherwise the base is
//   reduced first, then the exponent is scanned from its leading one, with a square for each later
//   bit and a multiply for each later set bit, plus any wait for a free output.
// One word in flight; the next word can be taken in the cycle after the result loads.
// A finished result waits in the output register while the next word is taken.
// Reset (sync, high): controller idle, no result pending, modulus = 1000000007.
// ---------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus by left-to-right square-and-multiply, with an
// APB-style register for the modulus.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_exponentiation
   import modexp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // request word
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [MOD_W-1:0]      req_base,
   input  logic [EXP_W-1:0]      req_exponent,

   // response word
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MOD_W-1:0]      rsp_result,

   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   modexp_cmd_type   cmd;
   modexp_sts_type   sts;
   logic [MOD_W-1:0] modulus_ff, modulus_in;
   logic             csr_write;
   logic             csr_hit;

   // Register decode: a single modulus register (31 bits, zero-extended to 32), selected by paddr[2] == 0.
   // Low address bits are don't-care.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_MODULUS);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign modulus_in = (csr_write && csr_hit) ? csr_pwdata[MOD_W-1:0] : modulus_ff;
   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-MOD_W){1'b0}}, modulus_ff} : '0;

   // Modulus is a control-visible register with a defined reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   // Sequencer: walks the exponent MSB first. Leading zero bits are only
   // shifted out; after the leading one every bit costs a square, and each
   // set bit an extra multiply by the reduced base.
   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: the base is first reduced mod modulus (base * 1 through the
   // multiplier), then every product goes through the same shared unit.
   modexp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .modulus      (modulus_ff),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_result   (rsp_result)
   );

   // One word at a time: the cycle after an accept the input is held off.
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "second word taken while busy")

endmodule
